/* hw/rtl/ffba_pkg.sv */
// Shared types and constants of the first-fit block allocator.
package ffba_pkg;

    localparam int SIZE_W = 29;
    localparam int ADDR_W = 32;
    localparam int REQ_W = 28;
    localparam int MERGE_W = 6;
    localparam int CFG_IDX_W = 2;

    localparam logic [CFG_IDX_W-1:0] CFG_HEAP_BASE = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_HEAP_BYTES = 2'd1;

    localparam logic MODE_ALLOC = 1'b0;
    localparam logic MODE_FREE = 1'b1;

    localparam logic [MERGE_W-1:0] MERGE_MAX = 6'd63;
    localparam logic [ADDR_W-1:0] ROUND_ADD = 32'd7;
    localparam logic [SIZE_W-1:0] ROUND_MASK = ~29'd7;
    // split only when the remainder exceeds header plus 8 bytes
    localparam int SPLIT_SLACK = 9;

    localparam logic [ADDR_W-1:0] HEAP_BASE_RESET = 32'hE000_0000;
    localparam logic [SIZE_W-1:0] HEAP_BYTES_RESET = 29'd65536;

    typedef enum logic [1:0] {
        STAT_OK      = 2'd0,
        STAT_NOFIT   = 2'd1,
        STAT_INVALID = 2'd2
    } status_t;

    typedef enum logic {
        ALU_ADD = 1'b0,
        ALU_SUB = 1'b1
    } alu_op_t;

    typedef struct packed {
        alu_op_t           op;
        logic [ADDR_W-1:0] a;
        logic [ADDR_W-1:0] b;
    } alu_in_t;

    typedef struct packed {
        logic [ADDR_W-1:0] res;
        logic              carry;   // carry out on add, borrow on subtract
        logic              zero;
    } alu_out_t;

    typedef struct packed {
        logic [SIZE_W-1:0] start;
        logic [SIZE_W-1:0] size;
        logic              free;
    } block_entry_t;

    typedef struct packed {
        logic              mode;
        logic [REQ_W-1:0]  request_size;
        logic [ADDR_W-1:0] pointer;
    } alloc_req_t;

    typedef struct packed {
        status_t            status;
        logic [ADDR_W-1:0]  address;
        logic [SIZE_W-1:0]  granted_size;
        logic [MERGE_W-1:0] merges;
    } alloc_rsp_t;

    typedef enum logic [4:0] {
        S_INIT,
        S_IDLE,
        S_A_NEED,
        S_A_RD,
        S_A_CMP,
        S_A_CHK,
        S_SH_RD,
        S_SH_WR,
        S_A_SPL1,
        S_A_SPL2,
        S_A_SPL3,
        S_A_TAKE,
        S_A_ADR1,
        S_A_ADR2,
        S_F_OFF1,
        S_F_OFF2,
        S_F_RANGE,
        S_F_RD,
        S_F_CMP,
        S_F_MARK,
        S_F_NXT,
        S_F_NXT_CMP,
        S_F_ABS,
        S_F_PRV,
        S_F_PRV_CMP,
        S_F_PABS,
        S_RM_RD,
        S_RM_WR,
        S_DONE
    } state_t;

endpackage

/* hw/rtl/first_fit_block_allocator_unit.sv */
// Top level of the first-fit block allocator: sequencer, registers and result stage.
//
// Requests arrive on req (valid/ready): mode 0 allocates request_size bytes,
// mode 1 frees pointer. Each request that no cfg write cuts short yields exactly one item on rsp
// (valid/ready) with status, address, granted_size and merges.
// The cfg channel writes heap_base (index 0) or heap_bytes (index 1); any
// such write rebuilds the table as one free block. cfg_ready is always high.
// Requests are taken one at a time; req_ready is high only while idle.
// Allocate: the first-fit search walks the table entries in order, and a split
// moves the entries behind the found block up by one to open a slot.
// Free: the search walks the entries to find the header, and each merge
// moves the entries behind it down by one to close the gap.
// All table walks go through the block memory, with its one write port and
// one read port, and the one shared adder.
// After reset, and after every cfg write, the block writes the first table
// entry in state S_INIT before it accepts a request.
// A finished result waits in the rsp register; a new request is accepted
// meanwhile, and its result is held back until the receiver takes the old one.
module first_fit_block_allocator_unit #(
    parameter int MAX_BLOCKS = 32,
    parameter int HEADER_BYTES = 16
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           req_valid,
    output logic                           req_ready,
    input  ffba_pkg::alloc_req_t           req,
    output logic                           rsp_valid,
    input  logic                           rsp_ready,
    output ffba_pkg::alloc_rsp_t           rsp,
    input  logic                           cfg_valid,
    output logic                           cfg_ready,
    input  logic [ffba_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [ffba_pkg::ADDR_W-1:0]    cfg_data
);
    import ffba_pkg::*;

    localparam int IDX_W = $clog2(MAX_BLOCKS);
    localparam int CNT_W = $clog2(MAX_BLOCKS + 1);
    localparam logic [ADDR_W-1:0] HDR = ADDR_W'(HEADER_BYTES);
    localparam logic [ADDR_W-1:0] SPLIT_MIN = ADDR_W'(HEADER_BYTES + SPLIT_SLACK);
    localparam logic [CNT_W-1:0] CNT_MAX = CNT_W'(MAX_BLOCKS);

    state_t             state_reg, state_next;
    logic [ADDR_W-1:0]  heap_base_reg, heap_base_next;
    logic [SIZE_W-1:0]  heap_bytes_reg, heap_bytes_next;
    logic [CNT_W-1:0]   count_reg, count_next;
    logic               rsp_valid_reg, rsp_valid_next;

    logic [IDX_W-1:0]   idx_reg, idx_next;
    logic [IDX_W-1:0]   j_reg, j_next;
    logic [SIZE_W-1:0]  need_reg, need_next;
    logic [SIZE_W-1:0]  rest_reg, rest_next;
    logic [SIZE_W-1:0]  cur_start_reg, cur_start_next;
    logic [SIZE_W-1:0]  cur_size_reg, cur_size_next;
    logic [ADDR_W-1:0]  tmp_reg, tmp_next;
    logic [SIZE_W-1:0]  granted_reg, granted_next;
    logic [MERGE_W-1:0] merges_reg, merges_next;
    status_t            status_reg, status_next;
    logic [ADDR_W-1:0]  addr_reg, addr_next;
    logic               prev_phase_reg, prev_phase_next;
    alloc_req_t         req_reg, req_next;
    alloc_rsp_t         rsp_reg, rsp_next;

    alu_in_t            alu_in;
    alu_out_t           alu_out;
    logic               wr_en;
    logic [IDX_W-1:0]   wr_addr;
    logic [IDX_W-1:0]   rd_addr;
    block_entry_t       wr_data;
    block_entry_t       rd_data;

    logic               cfg_hit;
    logic               idx_last;
    logic               nxt_last;
    logic               j_last_rm;
    logic               j_at_slot;
    logic [MERGE_W-1:0] merges_inc;

    ffba_alu u_alu (
        .alu_in  (alu_in),
        .alu_out (alu_out)
    );

    ffba_table #(
        .DEPTH (MAX_BLOCKS),
        .IDX_W (IDX_W)
    ) u_table (
        .clk     (clk),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (wr_data),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    assign req_ready = (state_reg == S_IDLE) && !cfg_valid;
    assign cfg_ready = 1'b1;
    assign rsp_valid = rsp_valid_reg;
    assign rsp = rsp_reg;

    always_comb
    begin
        case (cfg_index)
            CFG_HEAP_BASE:  cfg_hit = cfg_valid;
            CFG_HEAP_BYTES: cfg_hit = cfg_valid;
            default:        cfg_hit = 1'b0;
        endcase
    end

    assign idx_last = (CNT_W'(idx_reg) + CNT_W'(1)) == count_reg;
    assign nxt_last = idx_last;
    assign j_last_rm = (CNT_W'(j_reg) + CNT_W'(1)) == count_reg;
    assign j_at_slot = CNT_W'(j_reg) == (CNT_W'(idx_reg) + CNT_W'(1));
    assign merges_inc = (merges_reg == MERGE_MAX) ? merges_reg : merges_reg + MERGE_W'(1);

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            S_INIT:      state_next = S_IDLE;
            S_IDLE:
            begin
                if (req_valid && req_ready)
                begin
                    state_next = (req.mode == MODE_FREE) ? S_F_OFF1 : S_A_NEED;
                end
            end
            S_A_NEED:    state_next = S_A_RD;
            S_A_RD:      state_next = S_A_CMP;
            S_A_CMP:
            begin
                if (rd_data.free && !alu_out.carry)
                begin
                    state_next = S_A_CHK;
                end
                else if (idx_last)
                begin
                    state_next = S_DONE;
                end
                else
                begin
                    state_next = S_A_RD;
                end
            end
            S_A_CHK:
            begin
                state_next = (!alu_out.carry && count_reg != CNT_MAX) ? S_SH_RD : S_A_TAKE;
            end
            S_SH_RD:     state_next = j_at_slot ? S_A_SPL1 : S_SH_WR;
            S_SH_WR:     state_next = S_SH_RD;
            S_A_SPL1:    state_next = S_A_SPL2;
            S_A_SPL2:    state_next = S_A_SPL3;
            S_A_SPL3:    state_next = S_A_TAKE;
            S_A_TAKE:    state_next = S_A_ADR1;
            S_A_ADR1:    state_next = S_A_ADR2;
            S_A_ADR2:    state_next = S_DONE;
            S_F_OFF1:    state_next = S_F_OFF2;
            S_F_OFF2:    state_next = S_F_RANGE;
            S_F_RANGE:   state_next = alu_out.carry ? S_F_RD : S_DONE;
            S_F_RD:      state_next = S_F_CMP;
            S_F_CMP:
            begin
                if (alu_out.zero)
                begin
                    state_next = S_F_MARK;
                end
                else if (idx_last)
                begin
                    state_next = S_DONE;
                end
                else
                begin
                    state_next = S_F_RD;
                end
            end
            S_F_MARK:    state_next = S_F_NXT;
            S_F_NXT:     state_next = nxt_last ? S_F_PRV : S_F_NXT_CMP;
            S_F_NXT_CMP: state_next = rd_data.free ? S_F_ABS : S_F_PRV;
            S_F_ABS:     state_next = S_RM_RD;
            S_F_PRV:     state_next = (idx_reg == '0) ? S_DONE : S_F_PRV_CMP;
            S_F_PRV_CMP: state_next = rd_data.free ? S_F_PABS : S_DONE;
            S_F_PABS:    state_next = S_RM_RD;
            S_RM_RD:
            begin
                if (j_last_rm)
                begin
                    state_next = prev_phase_reg ? S_DONE : S_F_NXT;
                end
                else
                begin
                    state_next = S_RM_WR;
                end
            end
            S_RM_WR:     state_next = S_RM_RD;
            S_DONE:
            begin
                if (!rsp_valid_reg || rsp_ready)
                begin
                    state_next = S_IDLE;
                end
            end
            default:     state_next = S_INIT;
        endcase
        if (cfg_hit)
        begin
            state_next = S_INIT;
        end
    end

    // shared adder and table port controls
    always_comb
    begin
        alu_in = '{op: ALU_ADD, a: '0, b: '0};
        rd_addr = idx_reg;
        wr_en = 1'b0;
        wr_addr = idx_reg;
        wr_data = rd_data;
        case (state_reg)
            S_INIT:
            begin
                alu_in = '{op: ALU_SUB, a: ADDR_W'(heap_bytes_reg), b: HDR};
                wr_en = 1'b1;
                wr_addr = '0;
                wr_data = '{start: '0,
                            size: alu_out.carry ? '0 : alu_out.res[SIZE_W-1:0],
                            free: 1'b1};
            end
            S_A_NEED:
            begin
                alu_in = '{op: ALU_ADD, a: ADDR_W'(req_reg.request_size), b: ROUND_ADD};
            end
            S_A_CMP:
            begin
                alu_in = '{op: ALU_SUB, a: ADDR_W'(rd_data.size), b: ADDR_W'(need_reg)};
            end
            S_A_CHK:
            begin
                alu_in = '{op: ALU_SUB, a: ADDR_W'(rest_reg), b: SPLIT_MIN};
            end
            S_SH_RD:
            begin
                rd_addr = j_reg - IDX_W'(1);
            end
            S_SH_WR:
            begin
                wr_en = 1'b1;
                wr_addr = j_reg;
                wr_data = rd_data;
            end
            S_A_SPL1:
            begin
                alu_in = '{op: ALU_ADD, a: ADDR_W'(cur_start_reg), b: ADDR_W'(need_reg)};
            end
            S_A_SPL2:
            begin
                alu_in = '{op: ALU_ADD, a: tmp_reg, b: HDR};
            end
            S_A_SPL3:
            begin
                alu_in = '{op: ALU_SUB, a: ADDR_W'(rest_reg), b: HDR};
                wr_en = 1'b1;
                wr_addr = idx_reg + IDX_W'(1);
                wr_data = '{start: tmp_reg[SIZE_W-1:0],
                            size: alu_out.res[SIZE_W-1:0],
                            free: 1'b1};
            end
            S_A_TAKE:
            begin
                wr_en = 1'b1;
                wr_data = '{start: cur_start_reg, size: cur_size_reg, free: 1'b0};
            end
            S_A_ADR1:
            begin
                alu_in = '{op: ALU_ADD, a: heap_base_reg, b: ADDR_W'(cur_start_reg)};
            end
            S_A_ADR2:
            begin
                alu_in = '{op: ALU_ADD, a: tmp_reg, b: HDR};
            end
            S_F_OFF1:
            begin
                alu_in = '{op: ALU_SUB, a: req_reg.pointer, b: HDR};
            end
            S_F_OFF2:
            begin
                alu_in = '{op: ALU_SUB, a: tmp_reg, b: heap_base_reg};
            end
            S_F_RANGE:
            begin
                alu_in = '{op: ALU_SUB, a: tmp_reg, b: ADDR_W'(heap_bytes_reg)};
            end
            S_F_CMP:
            begin
                alu_in = '{op: ALU_SUB, a: ADDR_W'(rd_data.start), b: tmp_reg};
            end
            S_F_MARK:
            begin
                wr_en = 1'b1;
                wr_data = '{start: cur_start_reg, size: cur_size_reg, free: 1'b1};
            end
            S_F_NXT:
            begin
                rd_addr = idx_reg + IDX_W'(1);
            end
            S_F_NXT_CMP:
            begin
                alu_in = '{op: ALU_ADD, a: ADDR_W'(cur_size_reg), b: ADDR_W'(rd_data.size)};
            end
            S_F_ABS:
            begin
                alu_in = '{op: ALU_ADD, a: tmp_reg, b: HDR};
                wr_en = 1'b1;
                wr_data = '{start: cur_start_reg,
                            size: alu_out.res[SIZE_W-1:0],
                            free: 1'b1};
            end
            S_F_PRV:
            begin
                rd_addr = idx_reg - IDX_W'(1);
            end
            S_F_PRV_CMP:
            begin
                alu_in = '{op: ALU_ADD, a: ADDR_W'(rd_data.size), b: ADDR_W'(cur_size_reg)};
            end
            S_F_PABS:
            begin
                // cur_start holds the predecessor's start here
                alu_in = '{op: ALU_ADD, a: tmp_reg, b: HDR};
                wr_en = 1'b1;
                wr_addr = idx_reg - IDX_W'(1);
                wr_data = '{start: cur_start_reg,
                            size: alu_out.res[SIZE_W-1:0],
                            free: 1'b1};
            end
            S_RM_RD:
            begin
                rd_addr = j_reg + IDX_W'(1);
            end
            S_RM_WR:
            begin
                wr_en = 1'b1;
                wr_addr = j_reg;
                wr_data = rd_data;
            end
            default:
            begin
                wr_en = 1'b0;
            end
        endcase
    end

    // register updates
    always_comb
    begin
        heap_base_next = heap_base_reg;
        heap_bytes_next = heap_bytes_reg;
        count_next = count_reg;
        rsp_valid_next = rsp_valid_reg;
        idx_next = idx_reg;
        j_next = j_reg;
        need_next = need_reg;
        rest_next = rest_reg;
        cur_start_next = cur_start_reg;
        cur_size_next = cur_size_reg;
        tmp_next = tmp_reg;
        granted_next = granted_reg;
        merges_next = merges_reg;
        status_next = status_reg;
        addr_next = addr_reg;
        prev_phase_next = prev_phase_reg;
        req_next = req_reg;
        rsp_next = rsp_reg;

        if (rsp_valid_reg && rsp_ready)
        begin
            rsp_valid_next = 1'b0;
        end

        case (state_reg)
            S_INIT:
            begin
                count_next = CNT_W'(1);
            end
            S_IDLE:
            begin
                if (req_valid && req_ready)
                begin
                    req_next = req;
                end
            end
            S_A_NEED:
            begin
                need_next = alu_out.res[SIZE_W-1:0] & ROUND_MASK;
                idx_next = '0;
            end
            S_A_CMP:
            begin
                if (rd_data.free && !alu_out.carry)
                begin
                    cur_start_next = rd_data.start;
                    cur_size_next = rd_data.size;
                    rest_next = alu_out.res[SIZE_W-1:0];
                end
                else if (idx_last)
                begin
                    status_next = STAT_NOFIT;
                    addr_next = '0;
                    granted_next = '0;
                    merges_next = '0;
                end
                else
                begin
                    idx_next = idx_reg + IDX_W'(1);
                end
            end
            S_A_CHK:
            begin
                j_next = count_reg[IDX_W-1:0];
            end
            S_SH_WR:
            begin
                j_next = j_reg - IDX_W'(1);
            end
            S_A_SPL1:
            begin
                tmp_next = alu_out.res;
            end
            S_A_SPL2:
            begin
                tmp_next = alu_out.res;
            end
            S_A_SPL3:
            begin
                count_next = count_reg + CNT_W'(1);
                cur_size_next = need_reg;
            end
            S_A_ADR1:
            begin
                tmp_next = alu_out.res;
            end
            S_A_ADR2:
            begin
                status_next = STAT_OK;
                addr_next = alu_out.res;
                granted_next = cur_size_reg;
                merges_next = '0;
            end
            S_F_OFF1:
            begin
                tmp_next = alu_out.res;
            end
            S_F_OFF2:
            begin
                tmp_next = alu_out.res;
            end
            S_F_RANGE:
            begin
                idx_next = '0;
                if (!alu_out.carry)
                begin
                    status_next = STAT_INVALID;
                    addr_next = '0;
                    granted_next = '0;
                    merges_next = '0;
                end
            end
            S_F_CMP:
            begin
                if (alu_out.zero)
                begin
                    cur_start_next = rd_data.start;
                    cur_size_next = rd_data.size;
                    granted_next = rd_data.size;
                end
                else if (idx_last)
                begin
                    status_next = STAT_INVALID;
                    addr_next = '0;
                    granted_next = '0;
                    merges_next = '0;
                end
                else
                begin
                    idx_next = idx_reg + IDX_W'(1);
                end
            end
            S_F_MARK:
            begin
                status_next = STAT_OK;
                addr_next = '0;
                merges_next = '0;
                prev_phase_next = 1'b0;
            end
            S_F_NXT_CMP:
            begin
                tmp_next = alu_out.res;
            end
            S_F_ABS:
            begin
                cur_size_next = alu_out.res[SIZE_W-1:0];
                merges_next = merges_inc;
                j_next = idx_reg + IDX_W'(1);
                prev_phase_next = 1'b0;
            end
            S_F_PRV_CMP:
            begin
                cur_start_next = rd_data.start;
                tmp_next = alu_out.res;
            end
            S_F_PABS:
            begin
                merges_next = merges_inc;
                j_next = idx_reg;
                prev_phase_next = 1'b1;
            end
            S_RM_RD:
            begin
                if (j_last_rm)
                begin
                    count_next = count_reg - CNT_W'(1);
                end
            end
            S_RM_WR:
            begin
                j_next = j_reg + IDX_W'(1);
            end
            S_DONE:
            begin
                if (!rsp_valid_reg || rsp_ready)
                begin
                    rsp_next = '{status: status_reg, address: addr_reg,
                                 granted_size: granted_reg, merges: merges_reg};
                    rsp_valid_next = 1'b1;
                end
            end
            default:
            begin
                count_next = count_reg;
            end
        endcase

        if (cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                CFG_HEAP_BASE:  heap_base_next = cfg_data;
                CFG_HEAP_BYTES: heap_bytes_next = cfg_data[SIZE_W-1:0];
                default:        heap_base_next = heap_base_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_INIT;
            heap_base_reg <= HEAP_BASE_RESET;
            heap_bytes_reg <= HEAP_BYTES_RESET;
            count_reg <= CNT_W'(1);
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            heap_base_reg <= heap_base_next;
            heap_bytes_reg <= heap_bytes_next;
            count_reg <= count_next;
            rsp_valid_reg <= rsp_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        idx_reg <= idx_next;
        j_reg <= j_next;
        need_reg <= need_next;
        rest_reg <= rest_next;
        cur_start_reg <= cur_start_next;
        cur_size_reg <= cur_size_next;
        tmp_reg <= tmp_next;
        granted_reg <= granted_next;
        merges_reg <= merges_next;
        status_reg <= status_next;
        addr_reg <= addr_next;
        prev_phase_reg <= prev_phase_next;
        req_reg <= req_next;
        rsp_reg <= rsp_next;
    end

endmodule

/* hw/rtl/ffba_alu.sv */
// Shared 32-bit add/subtract unit with carry and zero flags.
module ffba_alu (
    input  ffba_pkg::alu_in_t  alu_in,
    output ffba_pkg::alu_out_t alu_out
);
    import ffba_pkg::*;

    logic [ADDR_W:0] wide;

    always_comb
    begin
        case (alu_in.op)
            ALU_SUB: wide = {1'b0, alu_in.a} - {1'b0, alu_in.b};
            default: wide = {1'b0, alu_in.a} + {1'b0, alu_in.b};
        endcase
        alu_out.res = wide[ADDR_W-1:0];
        alu_out.carry = wide[ADDR_W];
        alu_out.zero = (wide[ADDR_W-1:0] == '0);
    end

endmodule

/* hw/rtl/ffba_table.sv */
// Block table memory: one write port, one registered read port.
module ffba_table #(
    parameter int DEPTH = 32,
    parameter int IDX_W = 5
) (
    input  logic                   clk,
    input  logic                   wr_en,
    input  logic [IDX_W-1:0]       wr_addr,
    input  ffba_pkg::block_entry_t wr_data,
    input  logic [IDX_W-1:0]       rd_addr,
    output ffba_pkg::block_entry_t rd_data
);
    import ffba_pkg::*;

    block_entry_t mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge clk)
    begin
        rd_data <= mem[rd_addr];
    end

endmodule

/* verif/first_fit_block_allocator_unit_tb.sv */
// Self-checking testbench for the first-fit block allocator: table predictor, stimulus, checks.
module first_fit_block_allocator_unit_tb;
    import ffba_pkg::*;

    localparam int HDR = 16;
    localparam int MAX_BLK = 32;
    localparam int SPLIT_MIN = HDR + 8;
    localparam int CLK_PERIOD = 8;
    localparam int RESET_CYCLES = 12;
    localparam int LONG_HOLD = 400;
    localparam int DRAIN_CYCLES = 200;
    localparam int TIMEOUT_CYCLES = 1000000;
    localparam int TINY_HEAP = 8;

    // Mirror of the block table; expected responses wait in a queue.
    class alloc_scoreboard;
        logic [ADDR_W-1:0] heap_base;
        logic [SIZE_W-1:0] heap_bytes;
        logic [SIZE_W-1:0] blk_start [MAX_BLK];
        logic [SIZE_W-1:0] blk_size [MAX_BLK];
        bit                blk_free [MAX_BLK];
        int                blk_count;
        alloc_rsp_t        expected_rsp_q [$];
        logic [ADDR_W-1:0] last_addr;
        int errors, n_alloc_ok, n_nofit, n_invalid, n_free_ok, n_double, n_full_take;
        int n_merges, n_checked;

        function void rebuild_table();
            for (int k = 0; k < MAX_BLK; k++) begin
                blk_start[k] = '0;
                blk_size[k] = '0;
                blk_free[k] = 1'b0;
            end
            blk_count = 1;
            blk_size[0] = (heap_bytes >= HDR) ? heap_bytes - HDR : '0;
            blk_free[0] = 1'b1;
        endfunction

        function void reset_model();
            heap_base = HEAP_BASE_RESET;
            heap_bytes = HEAP_BYTES_RESET;
            rebuild_table();
        endfunction

        function void apply_cfg(logic [CFG_IDX_W-1:0] idx, logic [ADDR_W-1:0] data);
            if (idx == CFG_HEAP_BASE)
                heap_base = data;
            else if (idx == CFG_HEAP_BYTES)
                heap_bytes = data[SIZE_W-1:0];
            else
                return;
            rebuild_table();
        endfunction

        function void drop_entry(int k);
            for (int j = k; j + 1 < blk_count; j++) begin
                blk_start[j] = blk_start[j + 1];
                blk_size[j] = blk_size[j + 1];
                blk_free[j] = blk_free[j + 1];
            end
            blk_count--;
        endfunction

        function void absorb_next(int k);
            blk_size[k] = blk_size[k] + HDR + blk_size[k + 1];
            drop_entry(k + 1);
        endfunction

        function void predict_request(alloc_req_t r);
            alloc_rsp_t want;
            logic [ADDR_W-1:0] need, rest, offset;
            int i, found, m;
            want.status = STAT_OK;
            want.address = '0;
            want.granted_size = '0;
            want.merges = '0;
            if (r.mode == MODE_ALLOC) begin
                need = ({4'b0, r.request_size} + ROUND_ADD) & ~ROUND_ADD;
                want.status = STAT_NOFIT;
                for (i = 0; i < blk_count; i++) begin
                    if (blk_free[i] && {3'b0, blk_size[i]} >= need) begin
                        rest = blk_size[i] - need;
                        if (rest > SPLIT_MIN && blk_count < MAX_BLK) begin
                            for (int j = blk_count; j > i + 1; j--) begin
                                blk_start[j] = blk_start[j - 1];
                                blk_size[j] = blk_size[j - 1];
                                blk_free[j] = blk_free[j - 1];
                            end
                            blk_start[i + 1] = blk_start[i] + HDR + need;
                            blk_size[i + 1] = rest - HDR;
                            blk_free[i + 1] = 1'b1;
                            blk_count++;
                            blk_size[i] = need;
                        end else if (rest > SPLIT_MIN) begin
                            n_full_take++;
                        end
                        blk_free[i] = 1'b0;
                        want.status = STAT_OK;
                        want.address = heap_base + blk_start[i] + HDR;
                        want.granted_size = blk_size[i];
                        break;
                    end
                end
                if (want.status == STAT_OK)
                    n_alloc_ok++;
                else
                    n_nofit++;
            end else begin
                offset = r.pointer - HDR - heap_base;
                found = -1;
                if (offset < {3'b0, heap_bytes}) begin
                    for (i = 0; i < blk_count; i++) begin
                        if ({3'b0, blk_start[i]} == offset) begin
                            found = i;
                            break;
                        end
                    end
                end
                if (found < 0) begin
                    want.status = STAT_INVALID;
                    n_invalid++;
                end else begin
                    i = found;
                    m = 0;
                    if (blk_free[i])
                        n_double++;
                    want.granted_size = blk_size[i];
                    blk_free[i] = 1'b1;
                    while (i + 1 < blk_count && blk_free[i + 1]) begin
                        absorb_next(i);
                        m++;
                    end
                    if (i > 0 && blk_free[i - 1]) begin
                        absorb_next(i - 1);
                        m++;
                    end
                    if (m > MERGE_MAX)
                        m = MERGE_MAX;
                    want.merges = m;
                    n_merges += m;
                    n_free_ok++;
                end
            end
            last_addr = want.address;
            expected_rsp_q.push_back(want);
        endfunction

        function void check_response(alloc_rsp_t got);
            alloc_rsp_t want;
            if (expected_rsp_q.size() == 0) begin
                $error("unexpected response: status %0d address %h", got.status, got.address);
                errors++;
                return;
            end
            want = expected_rsp_q.pop_front();
            n_checked++;
            if (got.status !== want.status) begin
                $error("status: expected %0d, actual %0d", want.status, got.status);
                errors++;
            end
            if (got.address !== want.address) begin
                $error("address: expected %h, actual %h", want.address, got.address);
                errors++;
            end
            if (got.granted_size !== want.granted_size) begin
                $error("granted_size: expected %0d, actual %0d",
                       want.granted_size, got.granted_size);
                errors++;
            end
            if (got.merges !== want.merges) begin
                $error("merges: expected %0d, actual %0d", want.merges, got.merges);
                errors++;
            end
        endfunction

        function int pending();
            return expected_rsp_q.size();
        endfunction
    endclass

    logic                 clk;
    logic                 rst_n;
    logic                 req_valid;
    logic                 req_ready;
    alloc_req_t           req;
    logic                 rsp_valid;
    logic                 rsp_ready;
    alloc_rsp_t           rsp;
    logic                 cfg_valid;
    logic                 cfg_ready;
    logic [CFG_IDX_W-1:0] cfg_index;
    logic [ADDR_W-1:0]    cfg_data;

    alloc_scoreboard sb = new;
    int idle_pct = 10;
    bit hold_rsp = 1'b0;

    first_fit_block_allocator_unit #(
        .MAX_BLOCKS(MAX_BLK),
        .HEADER_BYTES(HDR)
    ) u_top (
        .clk(clk),
        .rst_n(rst_n),
        .req_valid(req_valid),
        .req_ready(req_ready),
        .req(req),
        .rsp_valid(rsp_valid),
        .rsp_ready(rsp_ready),
        .rsp(rsp),
        .cfg_valid(cfg_valid),
        .cfg_ready(cfg_ready),
        .cfg_index(cfg_index),
        .cfg_data(cfg_data)
    );

    initial
    begin
        clk = 1'b0;
        forever #(CLK_PERIOD / 2) clk = ~clk;
    end

    // check before predict so a result never meets the item taken on the same edge
    always @(posedge clk)
    begin
        if (rst_n) begin
            if (rsp_valid && rsp_ready)
                sb.check_response(rsp);
            if (cfg_valid && cfg_ready)
                sb.apply_cfg(cfg_index, cfg_data);
            if (req_valid && req_ready)
                sb.predict_request(req);
        end
    end

    // receiver: random stalls, plus one long hold-off on request
    initial
    begin
        rsp_ready <= 1'b0;
        forever begin
            @(negedge clk);
            if (hold_rsp) begin
                hold_rsp = 1'b0;
                rsp_ready <= 1'b0;
                repeat (LONG_HOLD) @(negedge clk);
            end else if ($urandom_range(0, 99) < idle_pct) begin
                rsp_ready <= 1'b0;
                repeat ($urandom_range(1, 19)) @(negedge clk);
            end else begin
                rsp_ready <= 1'b1;
            end
        end
    end

    function automatic alloc_req_t alloc_of(logic [REQ_W-1:0] size);
        alloc_req_t r;
        r.mode = MODE_ALLOC;
        r.request_size = size;
        r.pointer = $urandom;
        return r;
    endfunction

    function automatic alloc_req_t free_of(logic [ADDR_W-1:0] ptr);
        alloc_req_t r;
        r.mode = MODE_FREE;
        r.request_size = $urandom;
        r.pointer = ptr;
        return r;
    endfunction

    // mostly well-formed traffic: small allocations and frees of real blocks
    function automatic alloc_req_t pick_item(int alloc_pct, int unsigned max_req);
        alloc_req_t r;
        int unsigned roll, k;
        int t;
        r.request_size = $urandom;
        r.pointer = $urandom;
        k = $urandom_range(0, sb.blk_count - 1);
        if ($urandom_range(0, 99) < alloc_pct) begin
            r.mode = MODE_ALLOC;
            roll = $urandom_range(0, 19);
            if (roll < 16)
                r.request_size = $urandom_range(0, max_req);
            else if (roll < 18)
                r.request_size = sb.blk_size[k] - $urandom_range(0, 7);   // near exact fit
        end else begin
            r.mode = MODE_FREE;
            for (t = 0; t < 3 && sb.blk_free[k]; t++)
                k = $urandom_range(0, sb.blk_count - 1);
            roll = $urandom_range(0, 99);
            if (roll < 90)
                r.pointer = sb.heap_base + sb.blk_start[k] + HDR;
            else if (roll < 95)
                r.pointer = sb.heap_base + sb.blk_start[k] + HDR + 8;
        end
        return r;
    endfunction

    task automatic issue(alloc_req_t r);
        if ($urandom_range(0, 99) < idle_pct) begin
            req_valid <= 1'b0;
            repeat ($urandom_range(1, 19)) @(negedge clk);
        end
        req <= r;
        req_valid <= 1'b1;
        do @(posedge clk); while (!req_ready);
        @(negedge clk);
    endtask

    // both registers, back to back, only once every result is back
    task automatic configure(logic [ADDR_W-1:0] base, logic [ADDR_W-1:0] bytes);
        req_valid <= 1'b0;
        while (sb.pending() != 0) @(negedge clk);
        cfg_index <= CFG_HEAP_BASE;
        cfg_data <= base;
        cfg_valid <= 1'b1;
        do @(posedge clk); while (!cfg_ready);
        @(negedge clk);
        cfg_index <= CFG_HEAP_BYTES;
        cfg_data <= bytes;
        do @(posedge clk); while (!cfg_ready);
        @(negedge clk);
        cfg_valid <= 1'b0;
    endtask

    task automatic run_phase(logic [ADDR_W-1:0] base, logic [ADDR_W-1:0] bytes, int count,
                             int alloc_pct, int unsigned max_req, int pct);
        idle_pct = pct;
        configure(base, bytes);
        repeat (count) issue(pick_item(alloc_pct, max_req));
    endtask

    initial
    begin
        logic [ADDR_W-1:0] a0, a1, a2, a3;
        sb.reset_model();
        rst_n <= 1'b0;
        req_valid <= 1'b0;
        req <= '0;
        cfg_valid <= 1'b0;
        cfg_index <= CFG_HEAP_BASE;
        cfg_data <= '0;
        repeat (RESET_CYCLES) @(negedge clk);
        rst_n <= 1'b1;

        // directed: default region
        issue(alloc_of('0));                    // zero-byte request
        a0 = sb.last_addr;
        issue(alloc_of(1));
        a1 = sb.last_addr;
        issue(alloc_of(100));
        a2 = sb.last_addr;
        issue(alloc_of(20));
        a3 = sb.last_addr;
        issue(alloc_of('1));                    // largest request, no fit
        issue(alloc_of(HEAP_BYTES_RESET));
        issue(free_of(a1));
        issue(free_of(a1));                     // double free
        issue(free_of(a2));                     // merges into free predecessor
        issue(free_of(a0 + 8));                 // inside a block, no header there
        issue(free_of(HEAP_BASE_RESET - 4));    // below the region
        issue(free_of('1));
        issue(free_of(HEAP_BASE_RESET + HEAP_BYTES_RESET + HDR));   // just past the end
        issue(free_of(a3));                     // merges on both sides
        issue(free_of(a0));

        // directed: region smaller than one header
        configure(HEAP_BASE_RESET, TINY_HEAP);
        issue(alloc_of('0));
        a0 = sb.last_addr;
        issue(alloc_of(1));
        issue(free_of(a0));
        issue(free_of(a0 + 8));

        // random phases over several region settings
        run_phase($urandom, HEAP_BYTES_RESET, 20, 55, 3000, 10);
        hold_rsp = 1'b1;
        repeat (120) issue(pick_item(55, 3000));
        run_phase('0, 4096, 130, 85, 64, 30);              // fills the table
        run_phase(32'hFFFF_FFF8, 32, 60, 60, 16, 10);       // 32-byte region, wrapping base
        run_phase($urandom, 32'h1000_0000, 100, 55, 1 << 24, 10);
        run_phase('1, '1, 100, 55, 1 << 26, 15);            // field maximum size
        run_phase(HEAP_BASE_RESET, HEAP_BYTES_RESET, 170, 55, 2048, 0);

        req_valid <= 1'b0;
        while (sb.pending() != 0) @(negedge clk);
        repeat (DRAIN_CYCLES) @(negedge clk);

        $display("Checked %0d responses: %0d grants (%0d whole-block with full table), %0d no-fit,",
                 sb.n_checked, sb.n_alloc_ok, sb.n_full_take, sb.n_nofit);
        $display("%0d frees (%0d double) with %0d merges, %0d invalid pointers, 7 region settings.",
                 sb.n_free_ok, sb.n_double, sb.n_merges, sb.n_invalid);
        if (sb.errors == 0 && sb.pending() == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

    initial
    begin
        #(CLK_PERIOD * TIMEOUT_CYCLES);
        $error("timeout with %0d responses outstanding", sb.pending());
        $display("CHECK FAILED");
        $finish;
    end

endmodule

/* files.f */
hw/rtl/ffba_pkg.sv
hw/rtl/ffba_alu.sv
hw/rtl/ffba_table.sv
hw/rtl/first_fit_block_allocator_unit.sv
verif/first_fit_block_allocator_unit_tb.sv
